FILE: rtl/decimal_round_to_96bit_assert.svh
// ----------------------------------------------------------------------------
// decimal_round_to_96bit assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ROUND_TO_96BIT_ASSERT_SVH
`define DECIMAL_ROUND_TO_96BIT_ASSERT_SVH

`ifndef SYNTHESIS
`define DR96_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("decimal_round_to_96bit assertion failed");
`define DR96_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("decimal_round_to_96bit forbidden condition seen");
`else
`define DR96_ASSERT(lbl, clk, rst_n, prop)
`define DR96_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: rtl/dr96_pkg.sv
// ----------------------------------------------------------------------------
// dr96_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package dr96_pkg;

    localparam int DEFAULT_WIDE_BITS = 192;
    localparam int IN_WORDS          = 6;
    localparam int WORD_BITS         = 32;
    localparam int IN_WIDE_BITS      = IN_WORDS * WORD_BITS;
    localparam int SCALE_BITS        = 6;
    localparam int IN_TDATA_W        = 200;
    localparam int OUT_TDATA_W       = 136;
    localparam int OUT_MANT_BITS     = 96;

    localparam logic [SCALE_BITS-1:0] MAX_SCALE = 6'd28;
    localparam logic [3:0] HALF_DIGIT = 4'd5;

    // chunk of the serial divide by ten, remainder prepended makes 32 bits
    localparam int CHUNK_BITS  = 28;
    localparam int RECIP_SHIFT = 35;
    localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_POS_OVF = 2'd1;
    localparam logic [1:0] STATUS_NEG_OVF = 2'd2;

    localparam logic [31:0] OVF_WORD      = 32'hFFFFFFFF;
    localparam logic [31:0] OVF_FLAGS_NEG = 32'h80000000;
    localparam logic [31:0] OVF_FLAGS_POS = 32'h7FFFFFFF;

    typedef struct packed {
        logic load;
        logic div_step;
        logic round_step;
        logic out_load;
    } dr96_cmd_t;

    typedef struct packed {
        logic step_needed;
        logic last_chunk;
        logic out_stall;
    } dr96_status_t;

endpackage

`default_nettype wire

FILE: rtl/dr96_datapath.sv
// ----------------------------------------------------------------------------
// dr96_datapath
// wide mantissa register, chunk-serial divide by ten, rounding, output stage
// ----------------------------------------------------------------------------
`default_nettype none
`include "decimal_round_to_96bit_assert.svh"

module dr96_datapath #(
    parameter int WIDE_BITS = dr96_pkg::DEFAULT_WIDE_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire dr96_pkg::dr96_cmd_t              cmd,
    output dr96_pkg::dr96_status_t                stat,
    input  wire logic [dr96_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [dr96_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import dr96_pkg::*;

    localparam int CHUNKS    = (WIDE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int CW        = CHUNKS * CHUNK_BITS;
    localparam int IDX_W     = $clog2(CHUNKS);
    localparam int LOAD_BITS = (WIDE_BITS < IN_WIDE_BITS) ? WIDE_BITS : IN_WIDE_BITS;
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(CHUNKS - 1);

    logic [CW-1:0]          mant_reg, mant_next;
    logic [SCALE_BITS-1:0]  scale_reg, scale_next;
    logic                   sign_reg, sign_next;
    logic [3:0]             rem_reg, rem_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [31:0]            out_w0_reg, out_w1_reg, out_w2_reg, out_flags_reg;
    logic [31:0]            out_w0_next, out_w1_next, out_w2_next, out_flags_next;
    logic [1:0]             out_status_reg, out_status_next;

    logic [CW-1:0]          mant_load;
    logic [CHUNK_BITS-1:0]  chunk;
    logic [31:0]            cur;
    logic [63:0]            prod;
    logic [CHUNK_BITS-1:0]  quot;
    logic [31:0]            cur_rem;
    logic                   round_up;
    logic                   wide;

    always_comb
    begin
        mant_load = '0;
        mant_load[LOAD_BITS-1:0] = s_tdata[LOAD_BITS-1:0];
    end

    // one chunk of long division by ten per cycle, reciprocal multiply
    assign chunk   = mant_reg[idx_reg*CHUNK_BITS +: CHUNK_BITS];
    assign cur     = {rem_reg, chunk};
    assign prod    = 64'(cur) * 64'(RECIP_TEN);
    assign quot    = prod[RECIP_SHIFT +: CHUNK_BITS];
    assign cur_rem = cur - 32'({quot, 3'b000}) - 32'({quot, 1'b0});

    // half to even on the dropped digit, lsb of quotient is its parity
    assign round_up = (rem_reg > HALF_DIGIT) || ((rem_reg == HALF_DIGIT) && mant_reg[0]);
    assign wide     = |mant_reg[CW-1:OUT_MANT_BITS];

    assign stat.step_needed = (wide || (scale_reg > MAX_SCALE)) && (scale_reg != '0);
    assign stat.last_chunk  = (idx_reg == '0);
    assign stat.out_stall   = m_tvalid_reg && !m_tready;

    always_comb
    begin
        mant_next  = mant_reg;
        scale_next = scale_reg;
        sign_next  = sign_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        if (cmd.load)
        begin
            mant_next  = mant_load;
            scale_next = s_tdata[IN_WIDE_BITS +: SCALE_BITS];
            sign_next  = s_tdata[IN_WIDE_BITS + SCALE_BITS];
            rem_next   = '0;
            idx_next   = TOP_IDX;
        end
        else if (cmd.div_step)
        begin
            mant_next[idx_reg*CHUNK_BITS +: CHUNK_BITS] = quot;
            rem_next = cur_rem[3:0];
            idx_next = idx_reg - IDX_W'(1);
        end
        else if (cmd.round_step)
        begin
            mant_next  = mant_reg + CW'(round_up);
            scale_next = scale_reg - SCALE_BITS'(1);
            rem_next   = '0;
            idx_next   = TOP_IDX;
        end
    end

    always_comb
    begin
        out_w0_next     = out_w0_reg;
        out_w1_next     = out_w1_reg;
        out_w2_next     = out_w2_reg;
        out_flags_next  = out_flags_reg;
        out_status_next = out_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
            if (wide)
            begin
                out_w0_next     = OVF_WORD;
                out_w1_next     = OVF_WORD;
                out_w2_next     = OVF_WORD;
                out_flags_next  = sign_reg ? OVF_FLAGS_NEG : OVF_FLAGS_POS;
                out_status_next = sign_reg ? STATUS_NEG_OVF : STATUS_POS_OVF;
            end
            else
            begin
                out_w0_next     = mant_reg[31:0];
                out_w1_next     = mant_reg[63:32];
                out_w2_next     = mant_reg[95:64];
                out_flags_next  = {sign_reg, 7'b0, 2'b00, scale_reg, 16'h0000};
                out_status_next = STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mant_reg       <= mant_next;
        scale_reg      <= scale_next;
        sign_reg       <= sign_next;
        rem_reg        <= rem_next;
        idx_reg        <= idx_next;
        out_w0_reg     <= out_w0_next;
        out_w1_reg     <= out_w1_next;
        out_w2_reg     <= out_w2_next;
        out_flags_reg  <= out_flags_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_status_reg, out_flags_reg, out_w2_reg, out_w1_reg, out_w0_reg};

    `DR96_ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && m_tvalid_reg && !m_tready)
    `DR96_ASSERT(a_round_scale, clk, rst_n, cmd.round_step |=> (scale_reg == ($past(scale_reg) - 6'd1)))
    `DR96_ASSERT(a_ok_scale, clk, rst_n, (m_tvalid_reg && (out_status_reg == STATUS_OK)) |-> (out_flags_reg[23:16] <= 8'd28))

endmodule

`default_nettype wire

FILE: rtl/dr96_ctrl.sv
// ----------------------------------------------------------------------------
// dr96_ctrl
// sequencer for load, divide-by-ten chunk steps, rounding and result handoff
// ----------------------------------------------------------------------------
`default_nettype none
`include "decimal_round_to_96bit_assert.svh"

module dr96_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire dr96_pkg::dr96_status_t stat,
    output dr96_pkg::dr96_cmd_t         cmd
);
    import dr96_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.step_needed ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.last_chunk)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                state_next     = ST_CHECK;
            end
            ST_FINISH:
            begin
                if (!stat.out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `DR96_ASSERT(a_one_cmd, clk, rst_n, $onehot0({cmd.load, cmd.div_step, cmd.round_step, cmd.out_load}))
    `DR96_ASSERT(a_accept_check, clk, rst_n, (s_tvalid && s_tready) |=> (state_reg == ST_CHECK))
    `DR96_ASSERT(a_out_idle, clk, rst_n, cmd.out_load |=> (state_reg == ST_IDLE))

endmodule

`default_nettype wire

FILE: rtl/decimal_round_to_96bit.sv
// ----------------------------------------------------------------------------
// decimal_round_to_96bit
// reduces a wide decimal mantissa to 96 bits and scale <= 28, or flags overflow
// steps: s divide-by-ten steps, s = 0..63, each of C = ceil(WIDE_BITS/28)
//   chunks (7 at 192 bits) and a rounding step, plus any output stall
// a new item is accepted only once the last is handed to the output stage;
//   the 32x32 reciprocal multiplier does one 28-bit division chunk per cycle
// reset: rst_n asynchronous active low, clears sequencer and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_round_to_96bit #(
    parameter int WIDE_BITS = dr96_pkg::DEFAULT_WIDE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // mant_word0..mant_word5, scale_in, sign_in, zero pad
    input  wire logic [dr96_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_word0, out_word1, out_word2, out_flags_word, status, zero pad
    output logic [dr96_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import dr96_pkg::*;

    dr96_cmd_t    cmd;
    dr96_status_t stat;

    dr96_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dr96_datapath #(
        .WIDE_BITS (WIDE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
